// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CSE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define CSE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/cse_pkg.sv =====
package cse_pkg;

  localparam int ID_W     = 29;
  localparam int LAYOUT_W = 13;
  localparam int GAIN_W   = 28;
  localparam int WORD_W   = 32;
  localparam int DATA_W   = 64;
  localparam int CODE_W   = 8;
  localparam int NUM_CODES = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic FUNC_FRAME   = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  localparam logic [2:0] LAYOUT_BITFIELD = 3'd0;
  localparam logic [2:0] LAYOUT_BYTES_1  = 3'd1;
  localparam logic [2:0] LAYOUT_BYTES_2  = 3'd2;
  localparam logic [2:0] LAYOUT_BYTES_3  = 3'd3;
  localparam logic [2:0] LAYOUT_BYTES_4  = 3'd4;

  localparam logic [3:0] BITFIELD_MAX_CNT = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_ID     = 3'd0,
    CFG_FIELD_LAYOUT = 3'd1,
    CFG_WEIGHT       = 3'd2,
    CFG_BIAS         = 3'd3,
    CFG_THRESH_LOW   = 3'd4,
    CFG_THRESH_HIGH  = 3'd5,
    CFG_ALARM_MODE   = 3'd6,
    CFG_STATUS_CODES = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_NONE      = 3'd0,
    MODE_ABOVE     = 3'd1,
    MODE_BELOW     = 3'd2,
    MODE_INSIDE    = 3'd3,
    MODE_OUTSIDE   = 3'd4,
    MODE_HYST_HIGH = 3'd5,
    MODE_HYST_LOW  = 3'd6,
    MODE_STATUS    = 3'd7
  } alarm_mode_t;

  typedef struct packed {
    logic [ID_W-1:0]     match_id;
    logic [LAYOUT_W-1:0] field_layout;
    logic [GAIN_W-1:0]   weight;
    logic [WORD_W-1:0]   bias;
    logic [WORD_W-1:0]   thresh_low;
    logic [WORD_W-1:0]   thresh_high;
    alarm_mode_t         alarm_mode;
    logic [WORD_W-1:0]   status_codes;
  } cfg_t;

  // extraction result handed to the alarm stage
  typedef struct packed {
    logic              timeout;
    logic              hit;
    logic              upd;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] prod;
  } front_t;

endpackage

// ===== rtl/cse_cfg.sv =====
module cse_cfg
  import cse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [WORD_W-1:0]    wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_MATCH_ID:     cfg_nxt.match_id     = wr_data[ID_W-1:0];
        CFG_FIELD_LAYOUT: cfg_nxt.field_layout = wr_data[LAYOUT_W-1:0];
        CFG_WEIGHT:       cfg_nxt.weight       = wr_data[GAIN_W-1:0];
        CFG_BIAS:         cfg_nxt.bias         = wr_data;
        CFG_THRESH_LOW:   cfg_nxt.thresh_low   = wr_data;
        CFG_THRESH_HIGH:  cfg_nxt.thresh_high  = wr_data;
        CFG_ALARM_MODE:   cfg_nxt.alarm_mode   = alarm_mode_t'(wr_data[2:0]);
        CFG_STATUS_CODES: cfg_nxt.status_codes = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{weight: GAIN_W'(1), alarm_mode: MODE_NONE, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/cse_front.sv =====
module cse_front
  import cse_pkg::*;
(
  input  cfg_t              cfg,
  input  logic              func,
  input  logic [ID_W-1:0]   frame_id,
  input  logic [DATA_W-1:0] frame_data,
  output front_t            res
);

  logic [2:0]        ftype;
  logic [2:0]        start;
  logic [2:0]        shift;
  logic [3:0]        count;
  logic [3:0]        cnt_sat;
  logic [DATA_W-1:0] shifted;
  logic [CODE_W-1:0] bf_mask;
  logic [CODE_W-1:0] bf_val;
  logic [WORD_W-1:0] byte_mask;
  logic              is_frame;
  logic              id_hit;

  assign ftype = cfg.field_layout[2:0];
  assign start = cfg.field_layout[5:3];
  assign shift = cfg.field_layout[8:6];
  assign count = cfg.field_layout[12:9];

  // bytes past the payload shift in as zero
  assign shifted = frame_data >> {start, 3'b000};

  assign cnt_sat = (count > BITFIELD_MAX_CNT) ? BITFIELD_MAX_CNT : count;
  assign bf_mask = CODE_W'((9'd1 << cnt_sat) - 9'd1);
  assign bf_val  = (shifted[CODE_W-1:0] >> shift) & bf_mask;

  always_comb begin
    case (ftype)
      LAYOUT_BYTES_1: byte_mask = 32'h0000_00ff;
      LAYOUT_BYTES_2: byte_mask = 32'h0000_ffff;
      LAYOUT_BYTES_3: byte_mask = 32'h00ff_ffff;
      LAYOUT_BYTES_4: byte_mask = 32'hffff_ffff;
      default:        byte_mask = '0;
    endcase
  end

  assign is_frame = (func == FUNC_FRAME);
  assign id_hit   = is_frame && (frame_id == cfg.match_id);

  always_comb begin
    res.timeout = (func == FUNC_TIMEOUT);
    res.hit     = id_hit || res.timeout;
    res.upd     = id_hit && (ftype <= LAYOUT_BYTES_4);
    if (ftype == LAYOUT_BITFIELD) begin
      res.value = {{(WORD_W-CODE_W){1'b0}}, bf_val};
    end else begin
      res.value = shifted[WORD_W-1:0] & byte_mask;
    end
    res.prod = WORD_W'(res.value * {{(WORD_W-GAIN_W){1'b0}}, cfg.weight});
  end

endmodule

// ===== rtl/cse_back.sv =====
module cse_back
  import cse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cfg_t              cfg,
  input  front_t            s1,
  output logic [WORD_W-1:0] value,
  output logic              alarm
);

  logic [WORD_W-1:0] value_r;
  logic [WORD_W-1:0] value_nxt;
  logic              alarm_r;
  logic              alarm_nxt;
  logic              alarm_new;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] scaled;
  logic              ge_hi;
  logic              gt_hi;
  logic              le_lo;
  logic              lt_lo;
  logic [2:0]        n_codes;
  logic              code_hit;

  assign diff   = {1'b0, s1.prod} - {1'b0, cfg.bias};
  assign scaled = diff[WORD_W] ? '0 : diff[WORD_W-1:0];
  assign ge_hi  = scaled >= cfg.thresh_high;
  assign gt_hi  = scaled >  cfg.thresh_high;
  assign le_lo  = scaled <= cfg.thresh_low;
  assign lt_lo  = scaled <  cfg.thresh_low;

  assign n_codes = (cfg.thresh_low > WORD_W'(NUM_CODES)) ? 3'(NUM_CODES)
                                                          : cfg.thresh_low[2:0];

  always_comb begin
    code_hit = 1'b0;
    for (int j = 0; j < NUM_CODES; j++) begin
      if ((3'(j) < n_codes) &&
          (s1.value == {{(WORD_W-CODE_W){1'b0}}, cfg.status_codes[j*CODE_W +: CODE_W]})) begin
        code_hit = 1'b1;
      end
    end
  end

  always_comb begin
    alarm_new = alarm_r;
    case (cfg.alarm_mode)
      MODE_NONE:    alarm_new = alarm_r;
      MODE_ABOVE:   alarm_new = ge_hi;
      MODE_BELOW:   alarm_new = le_lo;
      MODE_INSIDE:  alarm_new = !lt_lo && !gt_hi;
      MODE_OUTSIDE: alarm_new = le_lo || ge_hi;
      MODE_HYST_HIGH: begin
        if (lt_lo) begin
          alarm_new = 1'b0;
        end else if (gt_hi) begin
          alarm_new = 1'b1;
        end
      end
      MODE_HYST_LOW: begin
        if (lt_lo) begin
          alarm_new = 1'b1;
        end else if (gt_hi) begin
          alarm_new = 1'b0;
        end
      end
      MODE_STATUS: begin
        if (n_codes != 3'd0) begin
          alarm_new = code_hit;
        end
      end
      default: alarm_new = alarm_r;
    endcase
  end

  always_comb begin
    value_nxt = value_r;
    alarm_nxt = alarm_r;
    if (load) begin
      if (s1.timeout) begin
        value_nxt = '0;
        alarm_nxt = 1'b0;
      end else if (s1.upd) begin
        value_nxt = s1.value;
        alarm_nxt = alarm_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      alarm_r <= 1'b0;
    end else begin
      value_r <= value_nxt;
      alarm_r <= alarm_nxt;
    end
  end

  assign value = value_r;
  assign alarm = alarm_r;

endmodule

// ===== rtl/can_signal_extract_alarm.sv =====
// CAN signal slot: extracts one signal from frames with a matching identifier,
// keeps it, and updates an alarm bit from it; a reception timeout clears both.
//
// Input channel: in_valid/in_stall with in_func (0 frame, 1 reception timeout),
// in_frame_id and in_frame_data. Result channel: out_valid/out_stall with
// out_accepted, out_signal_value and out_alarm, one result per request.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index, cfg_data;
// write only while no request is in flight.
//
// A request accepted on the input passes the input register, the extraction
// and multiply register, then the stage that subtracts the bias, compares
// and updates the held value and alarm, where its result shows.
// Throughput: one request per cycle; every stage advances each cycle while
// the result is not stalled.
// When out_stall is high the result holds and the pipeline fills; in_stall
// rises once all three stages are occupied.
// Reset (rst_n low at a clock edge) empties the pipeline and clears the held
// value, alarm and all config registers, except weight, which resets to 1.
module can_signal_extract_alarm
  import cse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [ID_W-1:0]      in_frame_id,
  input  logic [DATA_W-1:0]    in_frame_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_accepted,
  output logic [WORD_W-1:0]    out_signal_value,
  output logic                 out_alarm,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  cfg_t              cfg;
  logic              s0_v_r;
  logic              s0_v_nxt;
  logic              s0_func_r;
  logic [ID_W-1:0]   s0_id_r;
  logic [DATA_W-1:0] s0_data_r;
  front_t            front;
  front_t            s1_r;
  logic              s1_v_r;
  logic              s1_v_nxt;
  logic              out_v_r;
  logic              out_v_nxt;
  logic              out_acc_r;
  logic              out_adv;
  logic              s1_free;
  logic              in_load;
  logic              s1_load;
  logic              out_load;

  assign cfg_ready = 1'b1;

  cse_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_adv  = !out_v_r || !out_stall;
  assign s1_free  = !s1_v_r || out_adv;
  assign in_stall = s0_v_r && !s1_free;
  assign in_load  = in_valid && !in_stall;
  assign s1_load  = s0_v_r && s1_free;
  assign out_load = s1_v_r && out_adv;

  assign s0_v_nxt  = in_load || (s0_v_r && !s1_free);
  assign s1_v_nxt  = s1_load || (s1_v_r && !out_adv);
  assign out_v_nxt = out_load || (out_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s0_v_r  <= s0_v_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s0_func_r <= in_func;
      s0_id_r   <= in_frame_id;
      s0_data_r <= in_frame_data;
    end
    if (s1_load) begin
      s1_r <= front;
    end
    if (out_load) begin
      out_acc_r <= s1_r.hit;
    end
  end

  cse_front u_front (
    .cfg        (cfg),
    .func       (s0_func_r),
    .frame_id   (s0_id_r),
    .frame_data (s0_data_r),
    .res        (front)
  );

  // held value and alarm double as the result register
  cse_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (out_load),
    .cfg   (cfg),
    .s1    (s1_r),
    .value (out_signal_value),
    .alarm (out_alarm)
  );

  assign out_valid    = out_v_r;
  assign out_accepted = out_acc_r;

endmodule

// ===== rtl/cse_checker.sv =====
`include "assert_macros.svh"

module cse_checker
  import cse_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_accepted,
  input logic [WORD_W-1:0] out_signal_value,
  input logic              out_alarm
);

  logic [WORD_W:0] state_w;
  logic            stalled;
  logic            rejected;

  assign state_w  = {out_signal_value, out_alarm};
  assign stalled  = out_valid && out_stall;
  assign rejected = out_valid && !out_accepted;

  `CSE_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "result valid right after reset")
  `CSE_ASSERT(a_stall_holds, stalled |=> out_valid && $stable(state_w), "stalled result changed")
  `CSE_ASSERT(a_state_moves, $past(rst_n) && !$stable(state_w) |-> out_valid, "state moved idle")
  `CSE_ASSERT(a_reject_holds, $past(rst_n) && rejected |-> $stable(state_w), "reject moved state")

endmodule

bind can_signal_extract_alarm cse_checker u_cse_checker (.*);
